// ===== hw/rtl/min_tracking_stack_core_assert.svh =====
// ----------------------------------------------------------------------------
// min_tracking_stack_core_assert.svh
// Assertion macros for the min-tracking stack RTL.
// ----------------------------------------------------------------------------
`ifndef MIN_TRACKING_STACK_CORE_ASSERT_SVH
`define MIN_TRACKING_STACK_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define MTS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("min_tracking_stack_core: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted (active low).
`define MTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("min_tracking_stack_core: next-cycle check failed");

`endif

// ===== hw/rtl/mts_pkg.sv =====
// ----------------------------------------------------------------------------
// mts_pkg
// Command and status codes and fixed field widths of the min-tracking stack.
// ----------------------------------------------------------------------------
`default_nettype none

package mts_pkg;

    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH = 2'd0,
        CMD_POP  = 2'd1,
        CMD_TOP  = 2'd2,
        CMD_MIN  = 2'd3
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

endpackage

`default_nettype wire

// ===== hw/rtl/mts_cmd_if.sv =====
// ----------------------------------------------------------------------------
// mts_cmd_if
// Command channel: valid/ready handshake carrying a command and push value.
// ----------------------------------------------------------------------------
`default_nettype none

interface mts_cmd_if import mts_pkg::*; #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic [CMD_W-1:0]             command;
    logic signed [DATA_WIDTH-1:0] push_value;

    modport source (output valid, output command, output push_value, input ready);
    modport sink   (input valid, input command, input push_value, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/mts_rsp_if.sv =====
// ----------------------------------------------------------------------------
// mts_rsp_if
// Result channel: valid/ready handshake carrying value, status and count.
// ----------------------------------------------------------------------------
`default_nettype none

interface mts_rsp_if import mts_pkg::*; #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] result_value;
    logic [STATUS_W-1:0]          status;
    logic [COUNT_W-1:0]           entry_count;

    modport source (output valid, output result_value, output status,
                    output entry_count, input ready);
    modport sink   (input valid, input result_value, input status,
                    input entry_count, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/mts_ram.sv =====
// ----------------------------------------------------------------------------
// mts_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module mts_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end
endmodule

`default_nettype wire

// ===== hw/rtl/min_tracking_stack_core.sv =====
// ----------------------------------------------------------------------------
// min_tracking_stack_core
// Signed stack with running minimum, kept by encoding words in one RAM.
// ----------------------------------------------------------------------------
// Usage:
//   i_cmd carries push / pop / read top / read minimum; o_rsp returns one
//   result per command (value, status, entry count after the command).
//   Push, read-minimum and any command on an empty stack (or a push on a
//   full one) complete in the accept cycle: the result is valid the next
//   cycle, one command per cycle while the receiver takes each result. Pop
//   and read-top read the top word from the registered-read stack RAM in
//   a read state, during which the input is held off.
//   A push below the minimum stores 2*value - min and updates the minimum;
//   a pop that finds such a word restores the old minimum as 2*min - word.
//   The result sits in an output register; a new command is taken while it
//   waits only if it is being transferred in the same cycle, so a stalled
//   receiver stops the input after one result.
//   Reset empties the stack and sets the minimum to -1; the RAM contents
//   are not cleared (only entries below the stack pointer are ever read).
// ----------------------------------------------------------------------------
`default_nettype none

module min_tracking_stack_core import mts_pkg::*; #(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mts_cmd_if.sink    i_cmd,
    mts_rsp_if.source  o_rsp
);
    `include "min_tracking_stack_core_assert.svh"

    localparam int WORD_W = DATA_WIDTH + 2;
    localparam int AW     = $clog2(DEPTH);
    localparam int SPW    = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } t_state;

    t_state                       r_state, n_state;
    logic [SPW-1:0]               r_sp, n_sp;
    logic signed [DATA_WIDTH-1:0] r_min, n_min;
    logic                         r_is_pop, n_is_pop;
    logic                         r_out_valid, n_out_valid;
    logic signed [DATA_WIDTH-1:0] r_out_value, n_out_value;
    t_status                      r_out_status, n_out_status;
    logic [COUNT_W-1:0]           r_out_count, n_out_count;

    logic                     accept;
    logic                     ram_we, ram_re;
    logic [AW-1:0]            ram_waddr, ram_raddr;
    logic [WORD_W-1:0]        ram_wdata, ram_rdata;
    logic [SPW-1:0]           sp_dec;
    logic signed [WORD_W-1:0] min_w, val_w, word, prev_w;
    logic                     below_min, encoded, empty, full;

    mts_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign i_cmd.ready = (r_state == S_IDLE) && (!r_out_valid || o_rsp.ready);
    assign accept      = i_cmd.valid && i_cmd.ready;

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.result_value = r_out_value;
    assign o_rsp.status       = r_out_status;
    assign o_rsp.entry_count  = r_out_count;

    assign sp_dec    = r_sp - SPW'(1);
    assign empty     = (r_sp == '0);
    assign full      = (r_sp == SPW'(DEPTH));
    assign min_w     = {{2{r_min[DATA_WIDTH-1]}}, r_min};
    assign val_w     = {{2{i_cmd.push_value[DATA_WIDTH-1]}}, i_cmd.push_value};
    assign below_min = (i_cmd.push_value < r_min);
    assign word      = $signed(ram_rdata);
    assign encoded   = (word < min_w);
    // previous minimum, exact at word width
    assign prev_w    = (min_w <<< 1) - word;

    assign ram_waddr = r_sp[AW-1:0];
    assign ram_raddr = sp_dec[AW-1:0];

    always_comb begin
        n_state      = r_state;
        n_sp         = r_sp;
        n_min        = r_min;
        n_is_pop     = r_is_pop;
        n_out_valid  = r_out_valid && !o_rsp.ready;
        n_out_value  = r_out_value;
        n_out_status = r_out_status;
        n_out_count  = r_out_count;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        ram_wdata    = val_w;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_is_pop = (t_cmd'(i_cmd.command) == CMD_POP);
                    if (t_cmd'(i_cmd.command) == CMD_PUSH) begin
                        n_out_valid = 1'b1;
                        n_out_value = '0;
                        if (full) begin
                            n_out_status = ST_FULL;
                            n_out_count  = COUNT_W'(r_sp);
                        end else begin
                            ram_we = 1'b1;
                            if (empty) begin
                                // bottom entry holds the raw bits
                                ram_wdata = {2'b00, i_cmd.push_value};
                                n_min     = i_cmd.push_value;
                            end else if (below_min) begin
                                ram_wdata = (val_w <<< 1) - min_w;
                                n_min     = i_cmd.push_value;
                            end
                            n_sp         = r_sp + SPW'(1);
                            n_out_status = ST_OK;
                            n_out_count  = COUNT_W'(r_sp + SPW'(1));
                        end
                    end else if (empty) begin
                        n_out_valid  = 1'b1;
                        n_out_value  = '1;
                        n_out_status = ST_EMPTY;
                        n_out_count  = '0;
                    end else if (t_cmd'(i_cmd.command) == CMD_MIN) begin
                        n_out_valid  = 1'b1;
                        n_out_value  = r_min;
                        n_out_status = ST_OK;
                        n_out_count  = COUNT_W'(r_sp);
                    end else begin
                        ram_re  = 1'b1;
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                n_out_valid  = 1'b1;
                n_out_value  = encoded ? r_min : word[DATA_WIDTH-1:0];
                n_out_status = ST_OK;
                n_out_count  = COUNT_W'(r_is_pop ? sp_dec : r_sp);
                if (r_is_pop) begin
                    n_sp = sp_dec;
                    if (encoded) begin
                        n_min = prev_w[DATA_WIDTH-1:0];
                    end
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sp        <= '0;
            r_min       <= '1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sp        <= n_sp;
            r_min       <= n_min;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_is_pop     <= n_is_pop;
        r_out_value  <= n_out_value;
        r_out_status <= n_out_status;
        r_out_count  <= n_out_count;
    end

    `MTS_ASSERT_IMPL(a_sp_range, i_clk, i_rst_n, 1'b1, r_sp <= SPW'(DEPTH))
    `MTS_ASSERT_IMPL(a_read_slot_free, i_clk, i_rst_n, r_state == S_READ, !r_out_valid)
    `MTS_ASSERT_NEXT(a_pop_dec, i_clk, i_rst_n, (r_state == S_READ) && r_is_pop, r_sp == $past(sp_dec))
    `MTS_ASSERT_IMPL(a_empty_count, i_clk, i_rst_n, r_out_valid && (r_out_status == ST_EMPTY), r_out_count == '0)

endmodule

`default_nettype wire
